// File: design/skt_pkg.sv
// Shared constants for the sorted table key search block.
// Field widths, command codes and default table depth; no dependencies.
package skt_pkg;

   localparam int KEY_W               = 40;
   localparam int TXN_W               = 32;
   localparam int SLOT_W              = 10;
   localparam int COUNT_W             = 11;
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

endpackage

// File: design/skt_channels.sv
// Request and response channel interfaces for the key search block.
// Depends on skt_pkg for field widths.
interface skt_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [skt_pkg::SLOT_W-1:0] entry_slot;
   logic [skt_pkg::KEY_W-1:0]  stamp_key;
   logic [skt_pkg::TXN_W-1:0]  txn_number;

   modport source (output valid, command, entry_slot, stamp_key, txn_number, input ready);
   modport sink   (input valid, command, entry_slot, stamp_key, txn_number, output ready);
endinterface

interface skt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [skt_pkg::SLOT_W-1:0] found_slot;

   modport source (output valid, found, found_slot, input ready);
   modport sink   (input valid, found, found_slot, output ready);
endinterface

// File: design/skt_table_mem.sv
// Single-port-write, single-port-read table memory with registered read data.
// Holds key and transaction number of each slot; no package dependency.
module skt_table_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 72
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/sorted_table_key_search_top.sv
// Top level of the sorted table key search block.
// Depends on skt_pkg, skt_channels (skt_req_if, skt_rsp_if) and skt_table_mem.
//
// The block keeps a table of TABLE_DEPTH entries (40-bit YYYYMMDDhhmm key plus 32-bit
// transaction number) in one memory with a registered read port. A load transaction
// (command 0) writes one slot and returns found 0 in the next cycle; loads to slots at
// or above TABLE_DEPTH are dropped but still answered. A query transaction (command 1)
// binary-searches the first entry_count slots (csr register, saturated to TABLE_DEPTH),
// which software keeps in ascending key order. On a key hit with another transaction
// number it walks forward, then backward, over neighbors with the same full key.
// Every transaction returns exactly one response; found_slot is 0 when found is 0.
// Timing: a load is answered in the cycle after it is taken, and loads can follow back
// to back while the response side takes each response. Each table read of a query
// has an issue state (address) and then an evaluate state (compare). A search makes
// at most ceil(log2(n+1)) probes for n live entries, and a neighbor walk reads one
// neighbor at a time. No new request is taken while a query runs or while a response
// waits in the output register.
// Slots must be written before a query can reach them; reads of unwritten slots give
// undefined keys. Write csr_write_data only while the block is idle.
module sorted_table_key_search_top #(
   parameter int TABLE_DEPTH = skt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   skt_req_if.sink                     req_chan,
   skt_rsp_if.source                   rsp_chan,
   input  logic                        csr_write_en,
   input  logic [skt_pkg::COUNT_W-1:0] csr_write_data
);

   // index widths: AW addresses the table, CW holds 0..TABLE_DEPTH
   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int SCW = (CW > skt_pkg::COUNT_W) ? CW : skt_pkg::COUNT_W;
   localparam int DW  = skt_pkg::KEY_W + skt_pkg::TXN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH_ISSUE,
      ST_SRCH_EVAL,
      ST_UP_ISSUE,
      ST_UP_EVAL,
      ST_DN_ISSUE,
      ST_DN_EVAL,
      ST_FINISH
   } state_type;

   state_type                   state_ff, state_in;
   logic [skt_pkg::COUNT_W-1:0] count_cfg_ff;
   logic [CW-1:0]               low_ff, low_in;
   logic [CW-1:0]               high_ff, high_in;
   logic [CW-1:0]               live_ff, live_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic [AW-1:0]               mid_ff, mid_in;
   logic [AW-1:0]               hit_ff, hit_in;
   logic [skt_pkg::KEY_W-1:0]   qkey_ff, qkey_in;
   logic [skt_pkg::TXN_W-1:0]   qtxn_ff, qtxn_in;
   logic                        res_found_ff, res_found_in;
   logic [AW-1:0]               res_slot_ff, res_slot_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [skt_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;

   logic                        req_fire, rsp_fire, out_free;
   logic [SCW-1:0]              cnt_ext, depth_ext, slot_ext, res_slot_ext;
   logic [CW-1:0]               live_count;
   logic                        slot_ok;
   logic [CW-1:0]               span, mid_full, dn_idx;

   logic                        wr_en, rd_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic [DW-1:0]               rd_data;
   logic [skt_pkg::KEY_W-1:0]   rd_key;
   logic [skt_pkg::TXN_W-1:0]   rd_txn;
   logic                        key_lt, key_eq, txn_eq;

   // handshakes
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.found_slot = rsp_slot_ff;

   // count saturation and load slot range check
   assign cnt_ext    = SCW'(count_cfg_ff);
   assign depth_ext  = SCW'(TABLE_DEPTH);
   assign live_count = (cnt_ext > depth_ext) ? depth_ext[CW-1:0] : cnt_ext[CW-1:0];
   assign slot_ext   = SCW'(req_chan.entry_slot);
   assign slot_ok    = slot_ext < depth_ext;

   // probe point of the window [low, high)
   assign span     = high_ff - low_ff - 1'b1;
   assign mid_full = low_ff + (span >> 1);
   assign dn_idx   = idx_ff - 1'b1;

   // the one shared compare unit on the read-back entry
   assign rd_key = rd_data[DW-1 -: skt_pkg::KEY_W];
   assign rd_txn = rd_data[skt_pkg::TXN_W-1:0];
   assign key_lt = qkey_ff < rd_key;
   assign key_eq = qkey_ff == rd_key;
   assign txn_eq = qtxn_ff == rd_txn;

   assign wr_addr      = slot_ext[AW-1:0];
   assign res_slot_ext = SCW'(res_slot_ff);

   skt_table_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (DW)
   ) u_table_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_chan.stamp_key, req_chan.txn_number}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      live_in      = live_ff;
      idx_in       = idx_ff;
      mid_in       = mid_ff;
      hit_in       = hit_ff;
      qkey_in      = qkey_ff;
      qtxn_in      = qtxn_ff;
      res_found_in = res_found_ff;
      res_slot_in  = res_slot_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = mid_full[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.command == skt_pkg::CMD_LOAD) begin
                  wr_en        = slot_ok;
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_slot_in  = '0;
               end else begin
                  low_in   = '0;
                  high_in  = live_count;
                  live_in  = live_count;
                  qkey_in  = req_chan.stamp_key;
                  qtxn_in  = req_chan.txn_number;
                  state_in = ST_SRCH_ISSUE;
               end
            end
         end
         ST_SRCH_ISSUE: begin
            if (low_ff < high_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_full[AW-1:0];
               mid_in   = mid_full[AW-1:0];
               state_in = ST_SRCH_EVAL;
            end else begin
               res_found_in = 1'b0;
               state_in     = ST_FINISH;
            end
         end
         ST_SRCH_EVAL: begin
            if (key_lt) begin
               high_in  = CW'(mid_ff);
               state_in = ST_SRCH_ISSUE;
            end else if (!key_eq) begin
               low_in   = CW'(mid_ff) + 1'b1;
               state_in = ST_SRCH_ISSUE;
            end else if (txn_eq) begin
               res_found_in = 1'b1;
               res_slot_in  = mid_ff;
               state_in     = ST_FINISH;
            end else begin
               hit_in   = mid_ff;
               idx_in   = CW'(mid_ff) + 1'b1;
               state_in = ST_UP_ISSUE;
            end
         end
         ST_UP_ISSUE: begin
            if (idx_ff < live_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = ST_UP_EVAL;
            end else begin
               idx_in   = CW'(hit_ff);
               state_in = ST_DN_ISSUE;
            end
         end
         ST_UP_EVAL: begin
            if (!key_eq) begin
               idx_in   = CW'(hit_ff);
               state_in = ST_DN_ISSUE;
            end else if (txn_eq) begin
               res_found_in = 1'b1;
               res_slot_in  = idx_ff[AW-1:0];
               state_in     = ST_FINISH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_UP_ISSUE;
            end
         end
         ST_DN_ISSUE: begin
            if (idx_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = dn_idx[AW-1:0];
               idx_in   = dn_idx;
               state_in = ST_DN_EVAL;
            end else begin
               res_found_in = 1'b0;
               state_in     = ST_FINISH;
            end
         end
         ST_DN_EVAL: begin
            if (!key_eq) begin
               res_found_in = 1'b0;
               state_in     = ST_FINISH;
            end else if (txn_eq) begin
               res_found_in = 1'b1;
               res_slot_in  = idx_ff[AW-1:0];
               state_in     = ST_FINISH;
            end else begin
               state_in = ST_DN_ISSUE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_slot_in  = res_found_ff ? res_slot_ext[skt_pkg::SLOT_W-1:0] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_cfg_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            count_cfg_ff <= csr_write_data;
         end
      end
      low_ff       <= low_in;
      high_ff      <= high_in;
      live_ff      <= live_in;
      idx_ff       <= idx_in;
      mid_ff       <= mid_in;
      hit_ff       <= hit_in;
      qkey_ff      <= qkey_in;
      qtxn_ff      <= qtxn_in;
      res_found_ff <= res_found_in;
      res_slot_ff  <= res_slot_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

endmodule

// File: design/skt_checker.sv
// Port-level checker for sorted_table_key_search_top, bound to every instance.
// Depends on skt_pkg for widths and command codes.
module skt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_command,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_found,
   input logic [skt_pkg::SLOT_W-1:0]  rsp_found_slot
);

   // a stalled response stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_found_slot))
      else $error("response payload changed while stalled");

   // a miss never carries a slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_slot == '0)
      else $error("miss with nonzero slot");

   // a load is answered at once with a miss
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == skt_pkg::CMD_LOAD |=> rsp_valid && !rsp_found)
      else $error("load transaction not answered in the next cycle");

   // a query holds off the request side while it runs
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == skt_pkg::CMD_QUERY |=> !req_ready)
      else $error("request taken during a query");

endmodule

bind sorted_table_key_search_top skt_checker u_skt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_command    (req_chan.command),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_found      (rsp_chan.found),
   .rsp_found_slot (rsp_chan.found_slot)
);

// File: sim/skt_search_checker.sv
// Response checker for the sorted table key search block: mirrors the table and the
// entry count, predicts each response and compares it with what the block returns.
// Depends on skt_pkg and the channel interfaces in skt_channels.
module skt_search_checker #(
   parameter int DEPTH = skt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   skt_req_if                          req_mon,
   skt_rsp_if                          rsp_mon,
   input  logic                        csr_write_en,
   input  logic [skt_pkg::COUNT_W-1:0] csr_write_data,
   output int                          mismatch_count,
   output int                          awaiting
);

   typedef struct packed {
      logic                       found;
      logic [skt_pkg::SLOT_W-1:0] slot;
   } search_result_type;

   search_result_type           pending_results[$];
   logic [skt_pkg::KEY_W-1:0]   key_copy [DEPTH];
   logic [skt_pkg::TXN_W-1:0]   txn_copy [DEPTH];
   logic [skt_pkg::COUNT_W-1:0] live_setting;
   int                          errors;

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         key_copy[i] = '0;
         txn_copy[i] = '0;
      end
      live_setting = '0;
      errors       = 0;
   end

   // Binary search over the live window, then the walk over equal full keys:
   // forward first, backward only if forward found nothing.
   function automatic search_result_type search_table(logic [skt_pkg::KEY_W-1:0] key,
                                                      logic [skt_pkg::TXN_W-1:0] txn);
      search_result_type r;
      int                lo, hi, mid, i, live;
      bit                done;
      r    = '0;
      done = 1'b0;
      live = (live_setting > DEPTH) ? DEPTH : int'(live_setting);
      lo   = 0;
      hi   = live;
      while (lo < hi && !done) begin
         mid = lo + (hi - lo - 1) / 2;
         if (key < key_copy[mid]) begin
            hi = mid;
         end else if (key > key_copy[mid]) begin
            lo = mid + 1;
         end else begin
            done = 1'b1;
            if (txn_copy[mid] == txn) begin
               r.found = 1'b1;
               r.slot  = skt_pkg::SLOT_W'(mid);
            end
            i = mid + 1;
            while (!r.found && i < live && key_copy[i] == key) begin
               if (txn_copy[i] == txn) begin
                  r.found = 1'b1;
                  r.slot  = skt_pkg::SLOT_W'(i);
               end
               i++;
            end
            i = mid - 1;
            while (!r.found && i >= 0 && key_copy[i] == key) begin
               if (txn_copy[i] == txn) begin
                  r.found = 1'b1;
                  r.slot  = skt_pkg::SLOT_W'(i);
               end
               i--;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      search_result_type want, got;
      if (reset) begin
         pending_results.delete();
         live_setting = '0;
      end else begin
         // pop before push: a response never belongs to a transaction taken this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.found = rsp_mon.found;
            got.slot  = rsp_mon.found_slot;
            if (pending_results.size() == 0) begin
               if (errors < 10)
                  $display("%0t: response with none pending: found %0b slot %0d",
                           $realtime, got.found, got.slot);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (got.found !== want.found || got.slot !== want.slot) begin
                  if (errors < 10)
                     $display("%0t: mismatch: found exp %0b got %0b, slot exp %0d got %0d",
                              $realtime, want.found, got.found, want.slot, got.slot);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.command == skt_pkg::CMD_LOAD) begin
               if (req_mon.entry_slot < DEPTH) begin
                  key_copy[req_mon.entry_slot] = req_mon.stamp_key;
                  txn_copy[req_mon.entry_slot] = req_mon.txn_number;
               end
               pending_results.push_back('0);
            end else begin
               pending_results.push_back(search_table(req_mon.stamp_key,
                                                      req_mon.txn_number));
            end
         end
         if (csr_write_en)
            live_setting = csr_write_data;
      end
      mismatch_count <= errors;
      awaiting       <= pending_results.size();
   end

endmodule

// File: sim/sorted_table_key_search_top_tb.sv
// Testbench top for the sorted table key search block: clock, reset, stimulus and verdict.
// Depends on skt_pkg, skt_channels, sorted_table_key_search_top and skt_search_checker.
module sorted_table_key_search_top_tb;

   localparam int                        TABLE_SLOTS = skt_pkg::DEFAULT_TABLE_DEPTH;
   // largest legal stamp: year 9999, Dec 31, 23:59
   localparam logic [skt_pkg::KEY_W-1:0] KEY_MAX     = 40'd999_912_312_359;
   localparam logic [skt_pkg::KEY_W-1:0] MID_STAMP   = 40'd202_403_151_200;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_write_en;
   logic [skt_pkg::COUNT_W-1:0] csr_write_data;
   int                          fails;
   int                          awaiting;

   // idle_on: random bursts allowed in this phase; quiet: tail of the run, no idling
   bit                          idle_on = 1'b1;
   bit                          quiet   = 1'b0;
   int                          loads, searches;

   // what the current table phase put into slots 0..n-1
   logic [skt_pkg::KEY_W-1:0]   slot_key [TABLE_SLOTS];
   logic [skt_pkg::TXN_W-1:0]   slot_txn [TABLE_SLOTS];

   skt_req_if req_chan();
   skt_rsp_if rsp_chan();

   always #5 clock = ~clock;

   sorted_table_key_search_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   skt_search_checker #(.DEPTH(TABLE_SLOTS)) search_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mismatch_count (fails),
      .awaiting       (awaiting)
   );

   // Uniform stamp value in 0..lim.
   function automatic logic [skt_pkg::KEY_W-1:0] draw_key(logic [skt_pkg::KEY_W-1:0] lim);
      logic [63:0] r;
      r = {$urandom, $urandom};
      return skt_pkg::KEY_W'(r % ({24'd0, lim} + 64'd1));
   endfunction

   // One transaction on the request channel. A random gap may go in front of it; valid
   // is left high after acceptance so back-to-back transactions need no extra edge.
   task automatic issue(input logic cmd, input logic [skt_pkg::SLOT_W-1:0] slot,
                        input logic [skt_pkg::KEY_W-1:0] key,
                        input logic [skt_pkg::TXN_W-1:0] txn);
      if (!quiet && idle_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.entry_slot <= slot;
      req_chan.stamp_key  <= key;
      req_chan.txn_number <= txn;
      do @(posedge clock); while (!req_chan.ready);
      if (cmd == skt_pkg::CMD_LOAD)
         loads++;
      else
         searches++;
   endtask

   // Query; the slot field is a don't-care here, so it carries noise.
   task automatic ask(input logic [skt_pkg::KEY_W-1:0] key,
                      input logic [skt_pkg::TXN_W-1:0] txn);
      issue(skt_pkg::CMD_QUERY, skt_pkg::SLOT_W'($urandom), key, txn);
   endtask

   // entry_count may only change with the block idle: drop valid and wait until
   // every response has been taken before writing it.
   task automatic program_count(input logic [skt_pkg::COUNT_W-1:0] value);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Fill slots 0..n-1 with ascending keys; about a quarter repeat the previous key so
   // the neighbor walk gets exercised. scramble shuffles the table to break the order.
   task automatic build_and_load(input int n, input bit scramble);
      logic [skt_pkg::KEY_W-1:0] stride, k, tk;
      logic [skt_pkg::TXN_W-1:0] tt;
      int                        i, a, b, s;
      bit                        descending;
      stride     = KEY_MAX / (2 * n);
      k          = draw_key(KEY_MAX / 2);
      descending = $urandom_range(0, 1);
      for (i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 3) != 0)
            k = k + draw_key(stride);
         slot_key[i] = k;
         // now and then the same transaction number twice in a row
         slot_txn[i] = (i > 0 && $urandom_range(0, 15) == 0) ? slot_txn[i-1] : $urandom;
      end
      if (scramble) begin
         repeat (n / 2) begin
            a           = $urandom_range(0, n - 1);
            b           = $urandom_range(0, n - 1);
            tk          = slot_key[a];
            tt          = slot_txn[a];
            slot_key[a] = slot_key[b];
            slot_txn[a] = slot_txn[b];
            slot_key[b] = tk;
            slot_txn[b] = tt;
         end
      end
      for (i = 0; i < n; i++) begin
         s = descending ? n - 1 - i : i;
         issue(skt_pkg::CMD_LOAD, skt_pkg::SLOT_W'(s), slot_key[s], slot_txn[s]);
      end
   endtask

   // Searches against the table in slots 0..n-1: real entries most often, then wrong
   // transaction numbers, random and near-miss keys, and stray loads in between.
   task automatic probe_table(input int n, input int count);
      int i, j, pick, s;
      for (j = 0; j < count; j++) begin
         i    = $urandom_range(0, n - 1);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            ask(slot_key[i], slot_txn[i]);
         end else if (pick < 65) begin
            ask(slot_key[i], $urandom);
         end else if (pick < 77) begin
            ask(draw_key(KEY_MAX), $urandom);
         end else if (pick < 83) begin
            ask((slot_key[i] == 0) ? slot_key[i] : slot_key[i] - 1, slot_txn[i]);
         end else if (pick < 89) begin
            ask((slot_key[i] == KEY_MAX) ? slot_key[i] : slot_key[i] + 1, slot_txn[i]);
         end else begin
            // stray load: inside the window keep the key so the order holds
            s = $urandom_range(0, TABLE_SLOTS - 1);
            if (s < n) begin
               slot_txn[s] = $urandom;
               issue(skt_pkg::CMD_LOAD, skt_pkg::SLOT_W'(s), slot_key[s], slot_txn[s]);
            end else begin
               issue(skt_pkg::CMD_LOAD, skt_pkg::SLOT_W'(s), draw_key(KEY_MAX), $urandom);
            end
         end
      end
   endtask

   // Response side: ready drops for random bursts unless the phase says otherwise.
   initial begin
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!quiet && idle_on && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #8_000_000;
      $display("sorted_table_key_search_top_tb: done, errors");
      $finish;
   end

   initial begin
      int n, p;
      req_chan.valid      <= 1'b0;
      req_chan.command    <= skt_pkg::CMD_LOAD;
      req_chan.entry_slot <= '0;
      req_chan.stamp_key  <= '0;
      req_chan.txn_number <= '0;
      csr_write_en        <= 1'b0;
      csr_write_data      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // count is 0 out of reset: nothing can be found
      ask(KEY_MAX, 32'hFFFF_FFFF);
      // field extremes and a group of three equal keys
      issue(skt_pkg::CMD_LOAD, 10'd0,    '0,        32'h0000_0000);
      issue(skt_pkg::CMD_LOAD, 10'd1,    '0,        32'hFFFF_FFFF);
      issue(skt_pkg::CMD_LOAD, 10'd2,    MID_STAMP, 32'd7);
      issue(skt_pkg::CMD_LOAD, 10'd3,    MID_STAMP, 32'd9);
      issue(skt_pkg::CMD_LOAD, 10'd4,    MID_STAMP, 32'd11);
      issue(skt_pkg::CMD_LOAD, 10'd5,    KEY_MAX,   32'h8000_0000);
      issue(skt_pkg::CMD_LOAD, 10'd1023, KEY_MAX,   32'd1);
      // one live entry: slot 1 is outside the window
      program_count(11'd1);
      ask('0, 32'h0000_0000);
      ask('0, 32'hFFFF_FFFF);
      // four live entries: first probe is slot 1, the match sits behind it
      program_count(11'd4);
      ask('0, 32'h0000_0000);
      // six live entries: first probe is slot 2, start of the equal-key group
      program_count(11'd6);
      ask('0, 32'hFFFF_FFFF);
      ask(MID_STAMP, 32'd7);
      ask(MID_STAMP, 32'd11);
      ask(MID_STAMP, 32'd9);
      ask(MID_STAMP, 32'd5);
      ask(KEY_MAX, 32'h8000_0000);
      ask(KEY_MAX - 1, 32'd0);
      ask(40'd1, 32'd0);
      // back to an empty window
      program_count(11'd0);
      ask('0, 32'h0000_0000);

      // --- random: small tables, some shuffled, idling per phase ---
      for (p = 0; p < 11; p++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         n       = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 90)
                                               : $urandom_range(1, 24);
         build_and_load(n, $urandom_range(0, 5) == 0);
         program_count(skt_pkg::COUNT_W'(n));
         probe_table(n, 30);
      end

      // --- whole table, then counts past the depth (saturate) ---
      idle_on = 1'b1;
      build_and_load(TABLE_SLOTS, 1'b0);
      program_count(skt_pkg::COUNT_W'(TABLE_SLOTS));
      probe_table(TABLE_SLOTS, 50);
      program_count(11'd2047);
      probe_table(TABLE_SLOTS, 25);
      program_count(skt_pkg::COUNT_W'($urandom_range(TABLE_SLOTS + 1, 2046)));
      probe_table(TABLE_SLOTS, 15);

      // --- tail without any idling ---
      quiet = 1'b1;
      for (p = 0; p < 2; p++) begin
         n = $urandom_range(1, 16);
         build_and_load(n, 1'b0);
         program_count(skt_pkg::COUNT_W'(n));
         probe_table(n, 25);
      end

      // drain, then let a stray late response show up if there is one
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("summary: %0d load and %0d search transactions, tables of 1 to %0d entries",
               loads, searches, TABLE_SLOTS);
      $display("summary: entry counts from 0 to 2047, sorted and shuffled, %0d mismatches",
               fails);
      if (fails == 0 && awaiting == 0)
         $display("sorted_table_key_search_top_tb: done, clean");
      else
         $display("sorted_table_key_search_top_tb: done, errors");
      $finish;
   end

endmodule
